// ----- rtl/quadratic_root_solver_assert.svh -----
// Assertion macros for the quadratic root solver.
`ifndef QUADRATIC_ROOT_SOLVER_ASSERT_SVH
`define QUADRATIC_ROOT_SOLVER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define QRS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication.
`define QRS_ASSERT_NXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

// ----- rtl/qrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_pkg
// Shared widths and codes for the quadratic root solver.
// ----------------------------------------------------------------------------
package qrs_pkg;
	localparam int COEF_W = 16;
	localparam int VAL_W = 48;
	localparam int MAG_W = 34;
	localparam int RAD_W = 64;
	localparam int SQ_W = 32;
	localparam int NUM_W = 34;
	localparam int QUO_W = 34;
	localparam int DIV_STEPS = 34;
	localparam int SQ_STEPS = 32;
	localparam logic [1:0] KIND_REAL = 2'd0;
	localparam logic [1:0] KIND_CPLX = 2'd1;
	localparam logic [1:0] KIND_AZERO = 2'd2;
endpackage
`default_nettype wire

// ----- rtl/quadratic_root_solver.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Roots of a*x^2 + b*x + c, coefficients Q8.8, results Q32.16.
// ----------------------------------------------------------------------------
// Usage: drive coef_a/b/c and pulse start; a beat is taken on any edge with
// start high, and busy stays low, so a new beat may enter every cycle.
// Each beat gives exactly one result, shown for one cycle with done high:
// root_kind, first_value, second_value, saturated.
// Stages: 2 discriminant stages, 32 square-root stages,
// 1 numerator stage, 34 divider stages, 2 sign/output stages.
// Throughput: one beat per cycle, set by the fully pipelined root and divider.
// Reset clears all valid bits; no result appears until a beat enters.
// The receiver cannot stall: results are never held.
// ----------------------------------------------------------------------------
module quadratic_root_solver (
	input  wire                            clk,
	input  wire                            arst_n,
	input  wire                            start,
	output logic                           busy,
	input  wire  signed [15:0]             coef_a,
	input  wire  signed [15:0]             coef_b,
	input  wire  signed [15:0]             coef_c,
	output logic                           done,
	output logic [1:0]                     root_kind,
	output logic signed [47:0]             first_value,
	output logic signed [47:0]             second_value,
	output logic                           saturated
);
	logic vld_s1, vld_s2;
	logic signed [15:0] a_s1, b_s1, a_s2, b_s2;
	logic signed [31:0] bb_s1, ac_s1;
	logic signed [qrs_pkg::MAG_W:0] d_s2;
	logic [qrs_pkg::MAG_W-1:0] mag;
	logic [qrs_pkg::RAD_W-1:0] rad;
	logic [87:0] sq_side_in, sq_side;
	logic sq_vld;
	logic [qrs_pkg::SQ_W-1:0] sroot;
	logic signed [15:0] a_q, b_q;
	logic neg_q;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end
	always_ff @(posedge clk) begin
		a_s1 <= coef_a;
		b_s1 <= coef_b;
		bb_s1 <= coef_b * coef_b;
		ac_s1 <= coef_a * coef_c;
		a_s2 <= a_s1;
		b_s2 <= b_s1;
		d_s2 <= 35'(bb_s1) - (35'(ac_s1) <<< 2);
	end

	assign mag = d_s2[qrs_pkg::MAG_W] ? 34'(-d_s2) : 34'(d_s2);
	assign rad = {mag, 30'd0};
	assign sq_side_in = {55'd0, d_s2[qrs_pkg::MAG_W], a_s2, b_s2};

	qrs_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s2), .rad(rad),
		.side_in(sq_side_in), .out_vld(sq_vld), .root(sroot), .side_out(sq_side)
	);

	assign a_q = sq_side[31:16];
	assign b_q = sq_side[15:0];
	assign neg_q = sq_side[32];

	// numerator stage: N = -b*2^15 +/- S (complex: -b*2^15 and S), kept as signed 35 bits
	logic vld_s3;
	logic signed [34:0] n1_s3, n2_s3;
	logic signed [15:0] a_s3;
	logic kneg_s3;
	logic signed [34:0] nb;
	assign nb = -(35'(b_q) <<< 15);
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else vld_s3 <= sq_vld;
	end
	always_ff @(posedge clk) begin
		a_s3 <= a_q;
		kneg_s3 <= neg_q;
		if (neg_q) begin
			n1_s3 <= nb;
			n2_s3 <= 35'({1'b0, sroot});
		end else begin
			n1_s3 <= nb + 35'({1'b0, sroot});
			n2_s3 <= nb - 35'({1'b0, sroot});
		end
	end

	// magnitudes into the divider, signs carried alongside
	logic [qrs_pkg::NUM_W-1:0] m1, m2;
	logic [15:0] ma;
	logic s1, s2;
	assign m1 = n1_s3[34] ? 34'(-n1_s3) : 34'(n1_s3);
	assign m2 = n2_s3[34] ? 34'(-n2_s3) : 34'(n2_s3);
	assign ma = a_s3[15] ? 16'(-a_s3) : 16'(a_s3);
	assign s1 = n1_s3[34] ^ a_s3[15];
	assign s2 = n2_s3[34] ^ a_s3[15];

	logic dv_vld;
	logic [qrs_pkg::QUO_W-1:0] q1, q2;
	logic [3:0] dv_side;
	qrs_div u_div (
		.clk(clk), .arst_n(arst_n), .in_vld(vld_s3), .num1(m1), .num2(m2), .den(ma),
		.side_in({(a_s3 == 16'sd0), kneg_s3, s2, s1}),
		.out_vld(dv_vld), .quo1(q1), .quo2(q2), .side_out(dv_side)
	);

	logic vld_s4;
	logic signed [47:0] v1_s4, v2_s4;
	logic [1:0] kind_s4;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else vld_s4 <= dv_vld;
	end
	always_ff @(posedge clk) begin
		if (dv_side[3]) begin
			kind_s4 <= qrs_pkg::KIND_AZERO;
			v1_s4 <= '0;
			v2_s4 <= '0;
		end else begin
			kind_s4 <= dv_side[2] ? qrs_pkg::KIND_CPLX : qrs_pkg::KIND_REAL;
			v1_s4 <= dv_side[0] ? -48'({14'd0, q1}) : 48'({14'd0, q1});
			v2_s4 <= dv_side[1] ? -48'({14'd0, q2}) : 48'({14'd0, q2});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else done <= vld_s4;
	end
	always_ff @(posedge clk) begin
		root_kind <= kind_s4;
		first_value <= v1_s4;
		second_value <= v2_s4;
		saturated <= 1'b0;
	end

`include "quadratic_root_solver_assert.svh"
	`QRS_ASSERT_IMP(a_busy_low, 1'b1, !busy)
	`QRS_ASSERT_NXT(a_done_follows, vld_s4, done)
	`QRS_ASSERT_IMP(a_kind_legal, done, root_kind != 2'd3)
	`QRS_ASSERT_IMP(a_azero_zero, done && root_kind == qrs_pkg::KIND_AZERO,
		first_value == 48'sd0 && second_value == 48'sd0)
endmodule
`default_nettype wire

// ----- rtl/qrs_sqrt.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_sqrt
// Pipelined integer square root, one result bit per stage, with side data.
// ----------------------------------------------------------------------------
module qrs_sqrt (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_vld,
	input  wire  [qrs_pkg::RAD_W-1:0]    rad,
	input  wire  [87:0]                  side_in,
	output logic                         out_vld,
	output logic [qrs_pkg::SQ_W-1:0]     root,
	output logic [87:0]                  side_out
);
	localparam int N = qrs_pkg::SQ_STEPS;
	logic                         vld_s [0:N];
	logic [qrs_pkg::RAD_W-1:0]    x_s   [0:N];
	logic [qrs_pkg::SQ_W+1:0]     rem_s [0:N];
	logic [qrs_pkg::SQ_W-1:0]     r_s   [0:N];
	logic [87:0]                  sd_s  [0:N];

	always_comb begin
		vld_s[0] = in_vld;
		x_s[0] = rad;
		rem_s[0] = '0;
		r_s[0] = '0;
		sd_s[0] = side_in;
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [qrs_pkg::SQ_W+1:0] rin, trial;
		always_comb begin
			rin = {rem_s[i][qrs_pkg::SQ_W-1:0], x_s[i][qrs_pkg::RAD_W-1 -: 2]};
			trial = {r_s[i], 2'b01};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else vld_s[i+1] <= vld_s[i];
		end
		always_ff @(posedge clk) begin
			x_s[i+1] <= {x_s[i][qrs_pkg::RAD_W-3:0], 2'b00};
			sd_s[i+1] <= sd_s[i];
			if (rin >= trial) begin
				rem_s[i+1] <= rin - trial;
				r_s[i+1] <= {r_s[i][qrs_pkg::SQ_W-2:0], 1'b1};
			end else begin
				rem_s[i+1] <= rin;
				r_s[i+1] <= {r_s[i][qrs_pkg::SQ_W-2:0], 1'b0};
			end
		end
	end

	assign out_vld = vld_s[N];
	assign root = r_s[N];
	assign side_out = sd_s[N];
endmodule
`default_nettype wire

// ----- rtl/qrs_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// qrs_div
// Pipelined restoring divider for two numerators over one unsigned divisor.
// ----------------------------------------------------------------------------
module qrs_div (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_vld,
	input  wire  [qrs_pkg::NUM_W-1:0]    num1,
	input  wire  [qrs_pkg::NUM_W-1:0]    num2,
	input  wire  [qrs_pkg::COEF_W-1:0]   den,
	input  wire  [3:0]                   side_in,
	output logic                         out_vld,
	output logic [qrs_pkg::QUO_W-1:0]    quo1,
	output logic [qrs_pkg::QUO_W-1:0]    quo2,
	output logic [3:0]                   side_out
);
	localparam int N = qrs_pkg::DIV_STEPS;
	localparam int RW = qrs_pkg::COEF_W + 1;
	logic                          vld_s [0:N];
	logic [qrs_pkg::NUM_W-1:0]     n1_s  [0:N];
	logic [qrs_pkg::NUM_W-1:0]     n2_s  [0:N];
	logic [RW-1:0]                 r1_s  [0:N];
	logic [RW-1:0]                 r2_s  [0:N];
	logic [qrs_pkg::COEF_W-1:0]    d_s   [0:N];
	logic [3:0]                    sd_s  [0:N];

	always_comb begin
		vld_s[0] = in_vld;
		n1_s[0] = num1;
		n2_s[0] = num2;
		r1_s[0] = '0;
		r2_s[0] = '0;
		d_s[0] = den;
		sd_s[0] = side_in;
	end

	for (genvar i = 0; i < N; i++) begin : g_st
		logic [RW-1:0] t1, t2, dx;
		always_comb begin
			t1 = {r1_s[i][RW-2:0], n1_s[i][qrs_pkg::NUM_W-1]};
			t2 = {r2_s[i][RW-2:0], n2_s[i][qrs_pkg::NUM_W-1]};
			dx = {1'b0, d_s[i]};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_s[i+1] <= 1'b0;
			else vld_s[i+1] <= vld_s[i];
		end
		always_ff @(posedge clk) begin
			d_s[i+1] <= d_s[i];
			sd_s[i+1] <= sd_s[i];
			r1_s[i+1] <= (t1 >= dx) ? t1 - dx : t1;
			r2_s[i+1] <= (t2 >= dx) ? t2 - dx : t2;
			n1_s[i+1] <= {n1_s[i][qrs_pkg::NUM_W-2:0], (t1 >= dx)};
			n2_s[i+1] <= {n2_s[i][qrs_pkg::NUM_W-2:0], (t2 >= dx)};
		end
	end

	assign out_vld = vld_s[N];
	assign quo1 = n1_s[N];
	assign quo2 = n2_s[N];
	assign side_out = sd_s[N];
endmodule
`default_nettype wire

// ----- dv/tb_quadratic_root_solver.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_quadratic_root_solver
// Checks the quadratic root solver against a predictor of the roots. Directed
// extreme and random coefficient beats with random gaps are driven, every result
// is compared in order with the expected roots, kind and saturation flag.
// ----------------------------------------------------------------------------
module tb_quadratic_root_solver;

	typedef struct packed {
		logic [1:0]         kind;
		logic signed [47:0] v1;
		logic signed [47:0] v2;
		logic               sat;
	} roots_t;

	class root_scoreboard;
		roots_t pending[$];
		int     errors;

		function automatic longint unsigned int_sqrt(longint unsigned x);
			longint unsigned r, bitv;
			r = 0;
			bitv = 64'd1 << 62;
			while (bitv > x) bitv >>= 2;
			while (bitv != 0) begin
				if (x >= r + bitv) begin
					x -= r + bitv;
					r = (r >> 1) + bitv;
				end else begin
					r >>= 1;
				end
				bitv >>= 2;
			end
			return r;
		endfunction

		function automatic longint clip(longint v, ref logic sat);
			longint hi, lo;
			hi = 64'sh7FFF_FFFF_FFFF;
			lo = -hi - 1;
			if (v > hi) begin
				sat = 1'b1;
				return hi;
			end
			if (v < lo) begin
				sat = 1'b1;
				return lo;
			end
			return v;
		endfunction

		function void note_coefs(logic signed [15:0] a, logic signed [15:0] b,
				logic signed [15:0] c);
			roots_t          e;
			longint          la, lb, lc, disc, nb, s, r1, r2;
			longint unsigned mag;
			logic            sat;
			la = a;
			lb = b;
			lc = c;
			sat = 1'b0;
			e = '0;
			if (la == 0) begin
				e.kind = qrs_pkg::KIND_AZERO;
			end else begin
				disc = lb * lb - 4 * la * lc;
				mag = (disc >= 0) ? disc : -disc;
				s = int_sqrt(mag << 30);
				nb = -lb * 32768;
				if (disc >= 0) begin
					e.kind = qrs_pkg::KIND_REAL;
					r1 = (nb + s) / la;
					r2 = (nb - s) / la;
				end else begin
					e.kind = qrs_pkg::KIND_CPLX;
					r1 = nb / la;
					r2 = s / la;
				end
				e.v1 = clip(r1, sat);
				e.v2 = clip(r2, sat);
				e.sat = sat;
			end
			pending.push_back(e);
		endfunction

		function void check_roots(roots_t got);
			roots_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10) $display("unexpected result beat kind=%0d", got.kind);
				return;
			end
			e = pending.pop_front();
			if (got !== e) begin
				errors++;
				if (errors <= 10)
					$display({"mismatch: exp kind=%0d v1=%0d v2=%0d sat=%0d",
						" got kind=%0d v1=%0d v2=%0d sat=%0d"},
						e.kind, e.v1, e.v2, e.sat, got.kind, got.v1, got.v2, got.sat);
			end
		endfunction
	endclass

	logic clk = 0, arst_n = 0, start = 0;
	logic signed [15:0] coef_a = 0, coef_b = 0, coef_c = 0;
	wire busy, done, saturated;
	wire [1:0] root_kind;
	wire signed [47:0] first_value, second_value;
	root_scoreboard sb = new();
	int cycles = 0;

	quadratic_root_solver i_dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 200000) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && done)
			sb.check_roots({root_kind, first_value, second_value, saturated});

	always @(posedge clk)
		if (arst_n && start && !busy) sb.note_coefs(coef_a, coef_b, coef_c);

	function automatic logic [15:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return $urandom_range(0, 1) ? 16'sd0 : 16'sd1;
			3: return 16'($urandom_range(0, 15)) - 16'd8;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_beat(logic [15:0] a, logic [15:0] b, logic [15:0] c, int gap);
		repeat (gap) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		coef_a <= a;
		coef_b <= b;
		coef_c <= c;
		@(posedge clk);
		while (busy) @(posedge clk);
	endtask

	initial begin
		logic [15:0] ext[4];
		int gap;
		ext = '{16'h7FFF, 16'h8000, 16'h0000, 16'hFFFF};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (ext[i]) foreach (ext[j])
			send_beat(ext[i], ext[j], ext[(i + j) % 4], 0);
		send_beat(16'h0100, 16'h0200, 16'h0100, 1);
		send_beat(16'h0100, 16'h0000, 16'h0100, 0);
		send_beat(16'hFF00, 16'h0000, 16'h0100, 2);
		send_beat(16'h0000, 16'h1234, 16'h5678, 0);
		for (int n = 0; n < 1450; n++) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
			if ((n / 100) % 3 == 1) gap = 0;
			send_beat(pick_coef(), pick_coef(), pick_coef(), gap);
		end
		start <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		if (sb.errors == 0) $display("== PASS ==");
		else $display("== FAIL ==");
		$finish;
	end
endmodule
